>>> rtl/bdac_pkg.sv
// Shared constants and types for the binary to decimal ASCII converter.
`timescale 1ns / 1ps

package bdac_pkg;

  // Conversion size
  localparam int VALUE_BITS  = 64;
  localparam int MAX_DIGITS  = 20;

  // Port field widths
  localparam int ValueW      = 64;
  localparam int CharW       = 6;
  localparam int DigitCountW = 5;

  // Derived widths
  localparam int DigitW      = 4;
  localparam int BcdW        = DigitW * MAX_DIGITS;
  localparam int BitCntW     = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
  localparam int CntW        = $clog2(MAX_DIGITS + 1);

  // ASCII code of the character '0'
  localparam logic [CharW-1:0] AsciiZero = CharW'(48);

  // Status from the shift-and-add-3 unit to the emitter
  typedef struct packed {
    logic done;   // one-cycle pulse: BCD register holds the final digits
    logic ovf;    // value needed more digits than the register holds
  } bdac_stat_t;

endpackage

>>> rtl/binary_to_decimal_ascii_top.sv
// Top level of the binary to decimal ASCII converter.
`timescale 1ns / 1ps
//
// Usage:
//   Raise start with a value while busy is low; the request is taken at that
//   clock edge and busy rises on the next cycle. Only the low VALUE_BITS bits
//   of value_i are converted.
//   The digits come out most significant first, one per cycle, each shown for
//   exactly one cycle with result_valid_o high. Leading zeros are dropped; zero
//   gives the single digit '0'. digit_count_o carries the digit count on every
//   digit and last_digit_o marks the final one.
// Timing:
//   The shift-and-add-3 unit takes in one bit per cycle and then raises its
//   done flag, then the leading-zero strip drops one digit per cycle and the
//   digits follow back to back. A request keeps the block busy until the last
//   digit has been shown.
//   The next request is taken once busy falls after the last digit.
// Reset clears the controller to idle; no digits are pending afterwards.
// The receiver cannot stall: every digit is taken in the cycle it is shown.

module binary_to_decimal_ascii_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic [bdac_pkg::ValueW-1:0]         value_i,
  output logic                                result_valid_o,
  output logic [bdac_pkg::CharW-1:0]          digit_char_o,
  output logic                                last_digit_o,
  output logic [bdac_pkg::DigitCountW-1:0]    digit_count_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_SKIP = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]                   state_q;
  logic [bdac_pkg::CntW-1:0]    cnt_q;
  logic [bdac_pkg::CntW-1:0]    left_q;
  logic                         ovf_q;
  logic [bdac_pkg::BcdW-1:0]    buf_q;
  logic [bdac_pkg::BcdW-1:0]    bcd;
  logic [bdac_pkg::DigitW-1:0]  top_digit;
  logic                         load;
  logic                         skip_zero;
  bdac_pkg::bdac_stat_t         stat;

  assign load = start && !busy;

  bdac_dabble u_dabble (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (load),
    .value_i (value_i[bdac_pkg::VALUE_BITS-1:0]),
    .bcd_o   (bcd),
    .stat_o  (stat)
  );

  // Most significant digit still in the buffer
  assign top_digit = buf_q[bdac_pkg::BcdW-1 -: bdac_pkg::DigitW];
  // Strip a leading zero unless it is the only digit or the value wrapped
  assign skip_zero = (top_digit == '0) && (cnt_q > bdac_pkg::CntW'(1)) && !ovf_q;

  // Sequencer: convert, strip leading zeros, emit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      left_q  <= '0;
      ovf_q   <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (start) begin
            state_q <= ST_CONV;
          end
        end
        ST_CONV: begin
          if (stat.done) begin
            state_q <= ST_SKIP;
            cnt_q   <= bdac_pkg::CntW'(bdac_pkg::MAX_DIGITS);
            ovf_q   <= stat.ovf;
          end
        end
        ST_SKIP: begin
          if (skip_zero) begin
            cnt_q <= cnt_q - bdac_pkg::CntW'(1);
          end else begin
            state_q <= ST_EMIT;
            left_q  <= cnt_q;
          end
        end
        ST_EMIT: begin
          left_q <= left_q - bdac_pkg::CntW'(1);
          if (left_q == bdac_pkg::CntW'(1)) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Digit buffer: copied from the converter, then shifted one digit a cycle
  always_ff @(posedge clk_i) begin
    if (state_q == ST_CONV && stat.done) begin
      buf_q <= bcd;
    end else if ((state_q == ST_SKIP && skip_zero) || state_q == ST_EMIT) begin
      buf_q <= buf_q << bdac_pkg::DigitW;
    end
  end

  assign busy           = (state_q != ST_IDLE);
  assign result_valid_o = (state_q == ST_EMIT);
  assign digit_char_o   = bdac_pkg::AsciiZero + bdac_pkg::CharW'(top_digit);
  assign last_digit_o   = (state_q == ST_EMIT) && (left_q == bdac_pkg::CntW'(1));
  assign digit_count_o  = bdac_pkg::DigitCountW'(cnt_q);

`ifndef ASSERT_OFF
  // A taken request makes the block busy on the next cycle
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("request taken but block not busy");

  // Digits of one run come out back to back
  a_run_contig: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !last_digit_o) |=> result_valid_o)
    else $error("gap inside a digit run");

  // The last digit ends the run and frees the block
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_digit_o |=> (!result_valid_o && !busy))
    else $error("activity after last digit");

  // The first digit is never a leading zero, unless alone or wrapped
  a_no_lead_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(result_valid_o) |->
      (digit_char_o != bdac_pkg::AsciiZero || digit_count_o == bdac_pkg::DigitCountW'(1) ||
       ovf_q))
    else $error("leading zero emitted");

  // Digit count stays fixed through the run
  a_count_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !last_digit_o) |=> $stable(digit_count_o))
    else $error("digit count changed inside a run");
`endif

endmodule

>>> rtl/bdac_dabble.sv
// Bit-serial shift-and-add-3 unit: binary value in, packed BCD digits out.
`timescale 1ns / 1ps

module bdac_dabble (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           load_i,
  input  logic [bdac_pkg::VALUE_BITS-1:0] value_i,
  output logic [bdac_pkg::BcdW-1:0]       bcd_o,
  output bdac_pkg::bdac_stat_t           stat_o
);

  logic                            active_q;
  logic [bdac_pkg::BitCntW-1:0]    bitcnt_q;
  logic                            done_q;
  logic                            ovf_q;
  logic [bdac_pkg::VALUE_BITS-1:0] sh_q;
  logic [bdac_pkg::BcdW-1:0]       bcd_q;
  logic [bdac_pkg::BcdW-1:0]       adj;
  logic [bdac_pkg::BcdW-1:0]       bcd_d;
  logic [bdac_pkg::VALUE_BITS-1:0] sh_d;

  // Add 3 to every digit of 5 or more, so the next doubling carries in decimal
  always_comb begin
    for (int i = 0; i < bdac_pkg::MAX_DIGITS; i++) begin
      if (bcd_q[i*bdac_pkg::DigitW +: bdac_pkg::DigitW] >= bdac_pkg::DigitW'(5)) begin
        adj[i*bdac_pkg::DigitW +: bdac_pkg::DigitW] =
          bcd_q[i*bdac_pkg::DigitW +: bdac_pkg::DigitW] + bdac_pkg::DigitW'(3);
      end else begin
        adj[i*bdac_pkg::DigitW +: bdac_pkg::DigitW] =
          bcd_q[i*bdac_pkg::DigitW +: bdac_pkg::DigitW];
      end
    end
    // Double and bring in the next binary bit, MSB first
    bcd_d = {adj[bdac_pkg::BcdW-2:0], sh_q[bdac_pkg::VALUE_BITS-1]};
    sh_d  = sh_q << 1;
  end

  // Control: bit counter, done pulse, overflow sticky bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      bitcnt_q <= '0;
      done_q   <= 1'b0;
      ovf_q    <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (load_i) begin
        active_q <= 1'b1;
        bitcnt_q <= bdac_pkg::BitCntW'(bdac_pkg::VALUE_BITS - 1);
        ovf_q    <= 1'b0;
      end else if (active_q) begin
        // a bit leaving the top digit means the value is kept modulo 10^N
        ovf_q <= ovf_q | adj[bdac_pkg::BcdW-1];
        if (bitcnt_q == '0) begin
          active_q <= 1'b0;
          done_q   <= 1'b1;
        end else begin
          bitcnt_q <= bitcnt_q - bdac_pkg::BitCntW'(1);
        end
      end
    end
  end

  // Datapath shift registers
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      sh_q  <= value_i;
      bcd_q <= '0;
    end else if (active_q) begin
      sh_q  <= sh_d;
      bcd_q <= bcd_d;
    end
  end

  assign bcd_o       = bcd_q;
  assign stat_o.done = done_q;
  assign stat_o.ovf  = ovf_q;

endmodule
